>>> rtl/tdma_slot_scheduler_top_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef TDMA_SLOT_SCHEDULER_TOP_MACROS_SVH
`define TDMA_SLOT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tss_pkg.sv
// Types and constants shared by the TDMA slot scheduler modules.
`timescale 1ns / 1ps

package tss_pkg;

  // Node count that bounds the slot positions of one cycle.
  localparam logic [31:0] NODES = 32'd16;

  localparam logic [31:0] NEVER_TIME     = 32'hFFFF_FFFE;
  localparam logic [23:0] CYCLE_TIME_RST = 24'd10000;
  localparam logic [15:0] SLOT_TIME_RST  = 16'd100;
  localparam logic [15:0] GUARD_TIME_RST = 16'd20;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 168;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Event kinds
  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Frame types
  localparam logic [1:0] FT_HELLO = 2'd0;
  localparam logic [1:0] FT_NBR   = 2'd1;
  localparam logic [1:0] FT_MPR   = 2'd2;
  localparam logic [1:0] FT_OTHER = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_NODE_ADDR   = 3'd0;
  localparam logic [2:0] CFG_HELLO_SLOT  = 3'd1;
  localparam logic [2:0] CFG_HELLO_GUARD = 3'd2;
  localparam logic [2:0] CFG_NBR_SLOT    = 3'd3;
  localparam logic [2:0] CFG_NBR_GUARD   = 3'd4;
  localparam logic [2:0] CFG_MPR_SLOT    = 3'd5;
  localparam logic [2:0] CFG_MPR_GUARD   = 3'd6;
  localparam logic [2:0] CFG_CYCLE_TIME  = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [7:0]  rx_node;
    logic [1:0]  rx_frame_type;
    logic [31:0] rx_stamp;
  } item_t;

  // Configuration plus the terms derived from it.
  typedef struct packed {
    logic [5:0]  node_addr;
    logic [15:0] hello_slot;
    logic [15:0] hello_guard;
    logic [15:0] nbr_slot;
    logic [15:0] nbr_guard;
    logic [15:0] mpr_slot;
    logic [15:0] mpr_guard;
    logic [23:0] cycle_time;
    logic [31:0] cyc_base;     // cycle_time - node_addr * hello_slot, wrapped
    logic        addr_reload;  // node address was just written
  } cfg_t;

endpackage

>>> rtl/tss_cfg_regs.sv
// Configuration registers and the slot terms derived from them.
`timescale 1ns / 1ps

module tss_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tss_pkg::cfg_t                   cfg
);
  import tss_pkg::*;

  logic [5:0]  node_addr_r;
  logic [15:0] hello_slot_r, hello_guard_r;
  logic [15:0] nbr_slot_r, nbr_guard_r;
  logic [15:0] mpr_slot_r, mpr_guard_r;
  logic [23:0] cycle_time_r;
  logic [31:0] cyc_base_r, cyc_base_nxt;
  logic [21:0] addr_hslot_nxt;
  logic        reload_r;

  assign addr_hslot_nxt = node_addr_r * hello_slot_r;
  assign cyc_base_nxt   = {8'd0, cycle_time_r} - {10'd0, addr_hslot_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r   <= 6'd0;
      hello_slot_r  <= SLOT_TIME_RST;
      hello_guard_r <= GUARD_TIME_RST;
      nbr_slot_r    <= SLOT_TIME_RST;
      nbr_guard_r   <= GUARD_TIME_RST;
      mpr_slot_r    <= SLOT_TIME_RST;
      mpr_guard_r   <= GUARD_TIME_RST;
      cycle_time_r  <= CYCLE_TIME_RST;
      cyc_base_r    <= {8'd0, CYCLE_TIME_RST};
      reload_r      <= 1'b0;
    end else begin
      reload_r   <= 1'b0;
      cyc_base_r <= cyc_base_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_ADDR: begin
            node_addr_r <= cfg_wdata[5:0];
            reload_r    <= 1'b1;
          end
          CFG_HELLO_SLOT:  hello_slot_r  <= cfg_wdata[15:0];
          CFG_HELLO_GUARD: hello_guard_r <= cfg_wdata[15:0];
          CFG_NBR_SLOT:    nbr_slot_r    <= cfg_wdata[15:0];
          CFG_NBR_GUARD:   nbr_guard_r   <= cfg_wdata[15:0];
          CFG_MPR_SLOT:    mpr_slot_r    <= cfg_wdata[15:0];
          CFG_MPR_GUARD:   mpr_guard_r   <= cfg_wdata[15:0];
          CFG_CYCLE_TIME:  cycle_time_r  <= cfg_wdata[23:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.node_addr   = node_addr_r;
    cfg.hello_slot  = hello_slot_r;
    cfg.hello_guard = hello_guard_r;
    cfg.nbr_slot    = nbr_slot_r;
    cfg.nbr_guard   = nbr_guard_r;
    cfg.mpr_slot    = mpr_slot_r;
    cfg.mpr_guard   = mpr_guard_r;
    cfg.cycle_time  = cycle_time_r;
    cfg.cyc_base    = cyc_base_r;
    cfg.addr_reload = reload_r;
  end

endmodule

>>> rtl/tss_in_reg.sv
// Input register: captures one event transfer and holds it for the core.
`timescale 1ns / 1ps

module tss_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [tss_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            item_valid,
  output tss_pkg::item_t                  item,
  input  logic                            item_take
);
  import tss_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind          <= in_tuser;
      item_r.now_ms        <= in_tdata[31:0];
      item_r.rx_node       <= in_tdata[39:32];
      item_r.rx_frame_type <= in_tdata[41:40];
      item_r.rx_stamp      <= in_tdata[73:42];
    end
  end

endmodule

>>> rtl/tss_sched_core.sv
// Scheduler state, per-event update logic and the result register.
`timescale 1ns / 1ps

module tss_sched_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tss_pkg::cfg_t                    cfg,
  input  logic                             item_valid,
  input  tss_pkg::item_t                   item,
  output logic                             item_take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tss_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tss_pkg::*;

  // Scheduler state
  logic [31:0] next_tx_r, next_tx_nxt;
  logic [1:0]  next_type_r, next_type_nxt;
  logic [31:0] time_offset_r, time_offset_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] cycle_reset_r, cycle_reset_nxt;
  logic [63:0] heard_map_r, heard_map_nxt;
  logic [7:0]  last_node_r, last_node_nxt;
  logic [1:0]  last_type_r, last_type_nxt;
  logic [31:0] last_stamp_r, last_stamp_nxt;
  logic        heard_r, heard_nxt;
  logic        heard_nothing_r, heard_nothing_nxt;
  logic        sync_r, sync_nxt;
  logic        own_err, cleared;

  // Result register
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Datapath
  logic        s_lt, s_eq, addr_zero;
  logic [5:0]  slots_ahead;
  logic [31:0] after, diff;
  logic [31:0] mul_a;
  logic [15:0] mul_b, slot1, slot2, guard;
  logic [47:0] mul_p;
  logic [31:0] prod;
  logic [21:0] p2;
  logic [31:0] wait_t, wait_sel, rx_tx_time;
  logic [1:0]  rx_type;
  logic [31:0] off_calc, off_new, now_off;
  logic        sync_new;

  assign item_take  = item_valid && (!out_v_r || out_tready);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  assign addr_zero   = (cfg.node_addr == 6'd0);
  assign s_lt        = item.rx_node <  {2'd0, cfg.node_addr};
  assign s_eq        = item.rx_node == {2'd0, cfg.node_addr};
  assign slots_ahead = cfg.node_addr - item.rx_node[5:0] - 6'd1;
  assign after       = NODES - {24'd0, item.rx_node} - 32'd1;
  assign diff        = {26'd0, cfg.node_addr} - {24'd0, last_node_r};

  always_comb begin
    case (item.rx_frame_type)
      FT_HELLO: begin
        slot1 = cfg.hello_slot;
        slot2 = cfg.nbr_slot;
        guard = cfg.hello_guard;
      end
      FT_NBR: begin
        slot1 = cfg.nbr_slot;
        slot2 = cfg.mpr_slot;
        guard = cfg.nbr_guard;
      end
      default: begin
        slot1 = cfg.mpr_slot;
        slot2 = cfg.mpr_slot;
        guard = cfg.mpr_guard;
      end
    endcase
  end

  // One multiplier serves the slot count on receive and the sync offset on transmit.
  assign mul_a = (item.kind == KIND_TX) ? diff : (s_lt ? {26'd0, slots_ahead} : after);
  assign mul_b = (item.kind == KIND_TX) ? cfg.hello_slot : slot1;
  assign mul_p = mul_a * mul_b;
  assign prod  = mul_p[31:0];
  assign p2    = s_lt ? 22'd0 : cfg.node_addr * slot2;

  assign wait_t   = {16'd0, guard} + prod + {10'd0, p2};
  // Relay list from a later node: never, still offset by now (wraps).
  assign wait_sel = (item.rx_frame_type == FT_MPR && !s_lt) ? NEVER_TIME : wait_t;
  assign rx_tx_time = item.now_ms + wait_sel;

  always_comb begin
    case (item.rx_frame_type)
      FT_HELLO: rx_type = s_lt ? FT_HELLO : FT_NBR;
      FT_NBR:   rx_type = s_lt ? FT_NBR : FT_MPR;
      default:  rx_type = s_lt ? FT_MPR : FT_HELLO;
    endcase
  end

  assign off_calc = item.now_ms - (last_stamp_r + {16'd0, cfg.hello_guard} + prod);

  always_comb begin
    if (addr_zero) begin
      off_new  = 32'd0;
      sync_new = 1'b1;
    end else if (heard_r && next_type_r == FT_HELLO && last_type_r == FT_HELLO) begin
      off_new  = off_calc;
      sync_new = 1'b1;
    end else begin
      off_new  = time_offset_r;
      sync_new = sync_r;
    end
  end

  assign now_off = item.now_ms + off_new;

  always_comb begin
    next_tx_nxt       = next_tx_r;
    next_type_nxt     = next_type_r;
    time_offset_nxt   = time_offset_r;
    stamp_nxt         = stamp_r;
    cycle_reset_nxt   = cycle_reset_r;
    heard_map_nxt     = heard_map_r;
    last_node_nxt     = last_node_r;
    last_type_nxt     = last_type_r;
    last_stamp_nxt    = last_stamp_r;
    heard_nxt         = heard_r;
    heard_nothing_nxt = heard_nothing_r;
    sync_nxt          = sync_r;
    own_err           = 1'b0;
    cleared           = 1'b0;

    if (cfg.addr_reload) begin
      next_tx_nxt = addr_zero ? 32'd0 : NEVER_TIME;
    end

    if (item_take) begin
      case (item.kind)
        KIND_RX: begin
          last_node_nxt  = item.rx_node;
          last_stamp_nxt = item.rx_stamp;
          last_type_nxt  = item.rx_frame_type;
          heard_nxt      = 1'b1;
          if (item.rx_node[7:6] == 2'd0) begin
            heard_map_nxt = heard_map_r | (64'd1 << item.rx_node[5:0]);
          end
          if (item.rx_frame_type != FT_OTHER) begin
            if (s_eq) begin
              own_err = 1'b1;
            end else begin
              next_tx_nxt   = rx_tx_time;
              next_type_nxt = rx_type;
            end
          end
          if (item.rx_frame_type == FT_HELLO) begin
            heard_nothing_nxt = 1'b0;
          end
        end
        KIND_TX: begin
          next_tx_nxt     = NEVER_TIME;
          time_offset_nxt = off_new;
          sync_nxt        = sync_new;
          stamp_nxt       = sync_new ? now_off : item.now_ms;
          if (next_type_r == FT_HELLO) begin
            cycle_reset_nxt = sync_new ? now_off + cfg.cyc_base : NEVER_TIME;
          end
        end
        KIND_TICK: begin
          if (item.now_ms > cycle_reset_r) begin
            heard_nxt       = 1'b0;
            heard_map_nxt   = 64'd0;
            cycle_reset_nxt = NEVER_TIME;
            if (addr_zero || !heard_nothing_r) begin
              next_tx_nxt = 32'd0;
            end
            cleared = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data_nxt = {3'd0, cleared, own_err, sync_nxt, heard_map_nxt, cycle_reset_nxt,
                         stamp_nxt, next_type_nxt, next_tx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_tx_r       <= 32'd0;
      next_type_r     <= FT_HELLO;
      time_offset_r   <= 32'd0;
      stamp_r         <= 32'd0;
      cycle_reset_r   <= {8'd0, CYCLE_TIME_RST};
      heard_map_r     <= 64'd0;
      last_node_r     <= 8'd0;
      last_type_r     <= FT_HELLO;
      last_stamp_r    <= 32'd0;
      heard_r         <= 1'b0;
      heard_nothing_r <= 1'b1;
      sync_r          <= 1'b0;
      out_v_r         <= 1'b0;
    end else begin
      next_tx_r       <= next_tx_nxt;
      next_type_r     <= next_type_nxt;
      time_offset_r   <= time_offset_nxt;
      stamp_r         <= stamp_nxt;
      cycle_reset_r   <= cycle_reset_nxt;
      heard_map_r     <= heard_map_nxt;
      last_node_r     <= last_node_nxt;
      last_type_r     <= last_type_nxt;
      last_stamp_r    <= last_stamp_nxt;
      heard_r         <= heard_nxt;
      heard_nothing_r <= heard_nothing_nxt;
      sync_r          <= sync_nxt;
      if (item_take) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/tdma_slot_scheduler_top.sv
// TDMA slot scheduler: top level tying config, input register and core together.
`timescale 1ns / 1ps

// Slotted MAC scheduler for one node. Each event transfer (kind in in_tuser:
// frame received, own transmit slot, time check) yields exactly one result
// transfer with the scheduler state after that event plus the error and
// clear flags. Throughput is one event per clock while out_tready keeps the
// result register free; a stalled result holds the input register. The input
// register takes the event, then the update logic writes the state and the
// result register together. The longest path is the 32x16 slot multiplier
// followed by the time adders. Configuration writes reach the derived cycle
// base through its own register after the configuration register; write the
// registers while no event is in flight.
module tdma_slot_scheduler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // [1:0] kind
  input  logic [tss_pkg::IN_TUSER_W-1:0]  in_tuser,
  // [31:0] now_ms, [39:32] rx_node, [41:40] rx_frame_type, [73:42] rx_stamp
  input  logic [tss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] next_tx_time, [33:32] tx_type, [65:34] net_time,
  // [97:66] cycle_reset_time, [161:98] neighbor_map, [162] synced,
  // [163] own_id_error, [164] cycle_cleared
  output logic [tss_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tss_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_take;

  tss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tss_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tss_sched_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/tss_checker.sv
// Port-level checks on the scheduler result stream, bound to the top level.
`timescale 1ns / 1ps
`include "tdma_slot_scheduler_top_macros.svh"

module tss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tss_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tss_pkg::*;

  // A stalled result holds until the transfer.
  `TSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // The scheduled frame type is hello, neighbor list or relay list.
  `TSS_ASSERT_SAME(a_tx_type, out_tvalid, out_tdata[33:32] != FT_OTHER, "invalid tx_type")

  // A receive error and a cycle clear come from different event kinds.
  `TSS_ASSERT_SAME(a_flags_excl, out_tvalid, !(out_tdata[163] && out_tdata[164]), "both flags set")

  // A cleared cycle shows an empty map and a disarmed reset time.
  `TSS_ASSERT_SAME(a_clear_state, out_tvalid && out_tdata[164], out_tdata[161:98] == 64'd0 && out_tdata[97:66] == NEVER_TIME, "clear left state")

endmodule

bind tdma_slot_scheduler_top tss_checker u_tss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
